// ===== sv/fc2d_pkg.sv =====
package fc2d_pkg;

   localparam int DataWidth   = 32;
   localparam int MuWidth     = 18;
   localparam int MuFrac      = 16;
   localparam int FracBitsDef = 16;
   localparam int QuotWidth   = 40;

   localparam logic [1:0] RegimeSeparated = 2'd0;
   localparam logic [1:0] RegimeStick     = 2'd1;
   localparam logic [1:0] RegimeSlideNeg  = 2'd2;
   localparam logic [1:0] RegimeSlidePos  = 2'd3;

   localparam logic [DataWidth:0] PosMax = 33'h0_7FFF_FFFF;
   localparam logic [DataWidth:0] NegMax = 33'h0_8000_0000;

   typedef struct packed {
      logic                 sep;
      logic signed [31:0]   w_nn;
      logic signed [31:0]   w_nt;
      logic signed [31:0]   det;
      logic signed [31:0]   q_normal;
      logic [MuWidth-1:0]   mu;
      logic                 neg_n;
      logic [64:0]          mag_n;
      logic                 neg_t;
      logic [64:0]          mag_t;
   } front_item_type;

   // Saturate sign and magnitude (magnitude up to QuotWidth bits) to 32 bits.
   function automatic logic [32:0] clamp_sm(input logic neg, input logic [QuotWidth-1:0] m);
      logic [32:0] r;
      logic        sat;
      r   = '0;
      sat = 1'b0;
      if (neg) begin
         if (m > QuotWidth'(NegMax)) begin
            sat = 1'b1;
            r[31:0] = 32'h8000_0000;
         end else begin
            r[31:0] = 32'(-m);
         end
      end else begin
         if (m > QuotWidth'(PosMax)) begin
            sat = 1'b1;
            r[31:0] = 32'h7FFF_FFFF;
         end else begin
            r[31:0] = m[31:0];
         end
      end
      r[32] = sat;
      return r;
   endfunction

endpackage

// ===== sv/fc2d_divider.sv =====
// Pipelined restoring divider: one quotient bit per stage, capped at 2^40-1.
module fc2d_divider
   import fc2d_pkg::*;
#(
   parameter int NumWidth = 96,
   parameter int DenWidth = 66,
   parameter type tag_type = logic
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_en,
   input  logic [NumWidth-1:0] in_num,
   input  logic [DenWidth-1:0] in_den,
   input  tag_type             in_tag,
   input  logic                stall,
   output logic                out_valid,
   output logic [QuotWidth-1:0] out_quot,
   output tag_type             out_tag
);
   localparam int RemWidth = DenWidth + 1;

   logic                 v_ff   [NumWidth+1];
   logic [NumWidth-1:0]  n_ff   [NumWidth+1];
   logic [DenWidth-1:0]  d_ff   [NumWidth+1];
   logic [RemWidth-1:0]  r_ff   [NumWidth+1];
   logic [QuotWidth-1:0] q_ff   [NumWidth+1];
   tag_type              t_ff   [NumWidth+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NumWidth; s++) v_ff[s] <= 1'b0;
      end else if (!stall) begin
         v_ff[0] <= in_en;
         for (int s = 0; s < NumWidth; s++) v_ff[s+1] <= v_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         n_ff[0] <= in_num;
         d_ff[0] <= in_den;
         r_ff[0] <= '0;
         q_ff[0] <= '0;
         t_ff[0] <= in_tag;
         for (int s = 0; s < NumWidth; s++) begin
            logic [RemWidth-1:0]  rs;
            logic [QuotWidth:0]   qs;
            rs = {r_ff[s][RemWidth-2:0], n_ff[s][NumWidth-1-s]};
            qs = {q_ff[s], 1'b0};
            if (rs >= RemWidth'(d_ff[s])) begin
               rs = rs - RemWidth'(d_ff[s]);
               qs[0] = 1'b1;
            end
            if (qs[QuotWidth]) qs = {1'b0, {QuotWidth{1'b1}}};
            r_ff[s+1] <= rs;
            q_ff[s+1] <= qs[QuotWidth-1:0];
            n_ff[s+1] <= n_ff[s];
            d_ff[s+1] <= d_ff[s];
            t_ff[s+1] <= t_ff[s];
         end
      end
   end

   assign out_valid = v_ff[NumWidth];
   assign out_quot  = q_ff[NumWidth];
   assign out_tag   = t_ff[NumWidth];
endmodule

// ===== sv/fc2d_front.sv =====
// Accept items, form the Cramer numerators.
module fc2d_front
   import fc2d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [31:0]    req_w_nn,
   input  logic signed [31:0]    req_w_tn,
   input  logic signed [31:0]    req_w_nt,
   input  logic signed [31:0]    req_w_tt,
   input  logic signed [31:0]    req_det,
   input  logic signed [31:0]    req_q_normal,
   input  logic signed [31:0]    req_q_tangent,
   input  logic [MuWidth-1:0]    req_mu,
   input  logic                  stall,
   output logic                  out_valid,
   output front_item_type        out_item
);
   logic                 p_valid_ff;
   front_item_type       p_ff;
   logic signed [63:0]   a_ff, b_ff, c_ff, d_ff;
   logic                 valid_ff;
   front_item_type       item_ff;
   logic signed [64:0]   dn, dt;
   front_item_type       p_in, item_in;

   assign req_ready = !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else if (!stall) begin
         p_valid_ff <= req_valid;
         valid_ff   <= p_valid_ff;
      end
   end

   always_comb begin
      dn = 65'(a_ff) - 65'(b_ff);
      dt = 65'(c_ff) - 65'(d_ff);
      p_in          = '0;
      p_in.sep      = req_q_normal > 0;
      p_in.w_nn     = req_w_nn;
      p_in.w_nt     = req_w_nt;
      p_in.det      = req_det;
      p_in.q_normal = req_q_normal;
      p_in.mu       = req_mu;
      item_in       = p_ff;
      item_in.neg_n = dn[64];
      item_in.mag_n = dn[64] ? 65'(-dn) : 65'(dn);
      item_in.neg_t = dt[64];
      item_in.mag_t = dt[64] ? 65'(-dt) : 65'(dt);
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         a_ff    <= req_w_nt * req_q_tangent;
         b_ff    <= req_w_tt * req_q_normal;
         c_ff    <= req_w_tn * req_q_normal;
         d_ff    <= req_w_nn * req_q_tangent;
         p_ff    <= p_in;
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

// ===== sv/fc2d_back.sv =====
// Divide, cone test, edge projection. Whole pipeline advances together.
module fc2d_back
   import fc2d_pkg::*;
#(
   parameter int FracBits = FracBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  front_item_type     in_item,
   input  logic               stall,
   output logic               out_valid,
   output logic signed [31:0] out_p_normal,
   output logic signed [31:0] out_p_tangent,
   output logic [1:0]         out_regime,
   output logic               out_status
);
   localparam int Sh       = FracBits + MuFrac;
   localparam int EdgeNum  = 32 + Sh;
   localparam int EdgeDenW = 52;

   typedef struct packed {
      logic               sep;
      logic signed [31:0] w_nn;
      logic signed [31:0] w_nt;
      logic signed [31:0] det;
      logic signed [31:0] q_normal;
      logic [MuWidth-1:0] mu;
      logic               neg_n;
      logic               neg_t;
      logic               zn;
      logic               zt;
   } s1_type;

   typedef struct packed {
      logic               sep;
      logic               slide;
      logic               posedge_sel;
      logic signed [31:0] pn;
      logic signed [31:0] pt;
      logic               st;
      logic               deniszero;
      logic               numzero;
   } s2_type;

   // stage 1: both Cramer divisions
   logic [64:0] den_abs;
   s1_type      s1_in;
   logic        dv_valid;
   logic [QuotWidth-1:0] qn, qt;
   s1_type      dv_tag;
   logic        dv_valid2;

   always_comb begin
      den_abs = in_item.det[31] ? 65'(-65'(in_item.det)) : 65'(in_item.det);
      s1_in = '{sep: in_item.sep, w_nn: in_item.w_nn, w_nt: in_item.w_nt,
                det: in_item.det, q_normal: in_item.q_normal, mu: in_item.mu,
                neg_n: in_item.neg_n, neg_t: in_item.neg_t,
                zn: in_item.mag_n == '0, zt: in_item.mag_t == '0};
   end

   fc2d_divider #(.NumWidth(65), .DenWidth(65), .tag_type(s1_type)) u_div_n (
      .clock, .reset, .in_en(in_valid), .in_num(in_item.mag_n), .in_den(den_abs),
      .in_tag(s1_in), .stall, .out_valid(dv_valid), .out_quot(qn), .out_tag(dv_tag)
   );
   fc2d_divider #(.NumWidth(65), .DenWidth(65), .tag_type(logic [0:0])) u_div_t (
      .clock, .reset, .in_en(in_valid), .in_num(in_item.mag_t), .in_den(den_abs),
      .in_tag(1'b0), .stall, .out_valid(dv_valid2), .out_quot(qt), .out_tag()
   );

   // sdiv semantics, then cone test
   function automatic logic [32:0] sdiv_fix(input logic nneg, input logic dneg,
                                            input logic dz, input logic nz,
                                            input logic [QuotWidth-1:0] q);
      logic [32:0] r;
      if (dz) begin
         if (nz) begin
            r = {1'b1, 32'b0};
         end else begin
            r     = clamp_sm(nneg, {QuotWidth{1'b1}});
            r[32] = 1'b1;
         end
      end else if (q == '0) begin
         r = '0;
      end else begin
         r = clamp_sm(nneg != dneg, q);
      end
      return r;
   endfunction

   logic [32:0] rn, rt;
   logic signed [50:0] mupn;
   logic signed [47:0] ptw;
   logic [47:0] ptw_abs;
   logic signed [51:0] sum;
   s1_type      c_ff;
   s2_type      c2_ff, c2_in;
   logic        c_valid_ff;

   always_comb begin
      rn   = sdiv_fix(dv_tag.neg_n, dv_tag.det[31], dv_tag.det == 0, dv_tag.zn, qn);
      rt   = sdiv_fix(dv_tag.neg_t, dv_tag.det[31], dv_tag.det == 0, dv_tag.zt, qt);
      mupn = $signed({1'b0, dv_tag.mu}) * $signed(rn[31:0]);
      ptw  = 48'($signed(rt[31:0])) <<< MuFrac;
      ptw_abs = ptw[47] ? 48'(-ptw) : 48'(ptw);
      sum  = 52'(ptw) + 52'(mupn);
      c2_in.sep         = dv_tag.sep;
      c2_in.slide       = $signed({3'b0, ptw_abs}) > 51'(mupn);
      c2_in.posedge_sel = !sum[51];
      c2_in.pn          = rn[31:0];
      c2_in.pt          = rt[31:0];
      c2_in.st          = rn[32] | rt[32];
      c2_in.deniszero   = 1'b0;
      c2_in.numzero     = dv_tag.q_normal == 0;
   end

   always_ff @(posedge clock) begin
      if (reset) c_valid_ff <= 1'b0;
      else if (!stall) c_valid_ff <= dv_valid && dv_valid2;
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         c_ff  <= dv_tag;
         c2_ff <= c2_in;
      end
   end

   // edge divisor w_nn*2^16 -/+ mu*w_nt
   logic signed [50:0] muwnt_ff;
   logic signed [EdgeDenW-1:0] eden;
   logic [EdgeDenW-1:0] eden_abs;
   logic [63:0] qn_abs;
   logic [EdgeNum-1:0] enum_v;
   logic        e_valid_ff;
   s1_type      e_ff, e_in;
   s2_type      e2_ff, e2_in;

   always_comb begin
      eden = (EdgeDenW'(c_ff.w_nn) <<< MuFrac) +
             (c2_ff.posedge_sel ? EdgeDenW'(muwnt_ff) : -EdgeDenW'(muwnt_ff));
      eden_abs = eden[EdgeDenW-1] ? EdgeDenW'(-eden) : EdgeDenW'(eden);
      qn_abs = c_ff.q_normal[31] ? 64'(-64'(c_ff.q_normal)) : 64'(c_ff.q_normal);
      enum_v = EdgeNum'(qn_abs) << Sh;
      // keep the sign of the edge divisor in det for the tag
      e_in     = c_ff;
      e_in.det = {eden[EdgeDenW-1], 31'b0};
      e2_in    = c2_ff;
      e2_in.deniszero = eden == '0;
   end

   always_ff @(posedge clock) begin
      if (!stall) muwnt_ff <= $signed({1'b0, dv_tag.mu}) * dv_tag.w_nt;
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else if (!stall) e_valid_ff <= c_valid_ff;
   end

   logic [EdgeNum-1:0]  enum_ff;
   logic [EdgeDenW-1:0] eden_ff;
   always_ff @(posedge clock) begin
      if (!stall) begin
         e_ff    <= e_in;
         e2_ff   <= e2_in;
         enum_ff <= enum_v;
         eden_ff <= eden_abs;
      end
   end

   logic              ed_valid;
   logic [QuotWidth-1:0] eq;
   s2_type            ed_tag;
   s1_type            ed_tag1;
   logic              ed_valid1;

   fc2d_divider #(.NumWidth(EdgeNum), .DenWidth(EdgeDenW), .tag_type(s2_type)) u_div_e (
      .clock, .reset, .in_en(e_valid_ff), .in_num(enum_ff), .in_den(eden_ff),
      .in_tag(e2_ff), .stall, .out_valid(ed_valid), .out_quot(eq), .out_tag(ed_tag)
   );
   fc2d_divider #(.NumWidth(EdgeNum), .DenWidth(1), .tag_type(s1_type)) u_tag_e (
      .clock, .reset, .in_en(e_valid_ff), .in_num('0), .in_den(1'b1),
      .in_tag(e_ff), .stall, .out_valid(ed_valid1), .out_quot(), .out_tag(ed_tag1)
   );

   // final: edge quotient, tangential product, result register
   logic [32:0] epn;
   logic signed [31:0] pn_f;
   logic [67:0] tprod;
   logic [51:0] tm;
   logic [32:0] tres;
   logic        tneg;
   logic signed [31:0] fpn_ff, fpt_ff;
   logic [1:0]  freg_ff;
   logic        fst_ff, fvalid_ff;

   always_comb begin
      epn   = sdiv_fix(1'b0, ed_tag1.det[31], ed_tag.deniszero, ed_tag.numzero, eq);
      pn_f  = epn[31:0];
      tprod = {50'b0, ed_tag1.mu} * 68'(pn_f[31] ? 33'(-33'(pn_f)) : 33'(pn_f));
      tm    = tprod[MuFrac +: 52];
      tneg  = ed_tag.posedge_sel ? pn_f < 0 : pn_f > 0;
      tres  = (tm == '0) ? 33'b0 : clamp_sm(tneg, tm[QuotWidth-1:0] |
              {QuotWidth{|tm[51:QuotWidth]}});
   end

   assign out_valid = fvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) fvalid_ff <= 1'b0;
      else if (!stall) fvalid_ff <= ed_valid && ed_valid1;
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         if (ed_tag.sep) begin
            fpn_ff <= '0; fpt_ff <= '0; freg_ff <= RegimeSeparated; fst_ff <= 1'b0;
         end else if (!ed_tag.slide) begin
            fpn_ff <= ed_tag.pn; fpt_ff <= ed_tag.pt;
            freg_ff <= RegimeStick; fst_ff <= ed_tag.st;
         end else begin
            fpn_ff <= pn_f; fpt_ff <= tres[31:0];
            freg_ff <= ed_tag.posedge_sel ? RegimeSlidePos : RegimeSlideNeg;
            fst_ff <= ed_tag.st | epn[32] | tres[32];
         end
      end
   end

   assign out_p_normal  = fpn_ff;
   assign out_p_tangent = fpt_ff;
   assign out_regime    = freg_ff;
   assign out_status    = fst_ff;

   a_sep_zero: assert property (@(posedge clock) disable iff (reset)
      fvalid_ff && freg_ff == RegimeSeparated |-> fpn_ff == 0 && fpt_ff == 0)
      else $error("separated result not zero");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      stall && fvalid_ff |=> fvalid_ff && $stable(fpn_ff))
      else $error("result lost under stall");
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      dv_valid == dv_valid2 && ed_valid == ed_valid1)
      else $error("divider lanes out of step");
endmodule

// ===== sv/friction_contact_2d_local_solve_unit.sv =====
// Local solve of a 2D Coulomb friction contact. One item is accepted per cycle while
// req_ready is high, and results come back in order through the two bit-per-stage divider
// pipelines (Cramer solve, then edge projection). A stall on the result side freezes
// the back pipe only; the front keeps accepting until the two-entry queue between them
// fills, so req_ready depends on the queue fill and not on rsp_ready.
module friction_contact_2d_local_solve_unit
   import fc2d_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_w_nn,
   input  logic signed [31:0] req_w_tn,
   input  logic signed [31:0] req_w_nt,
   input  logic signed [31:0] req_w_tt,
   input  logic signed [31:0] req_det,
   input  logic signed [31:0] req_q_normal,
   input  logic signed [31:0] req_q_tangent,
   input  logic [MuWidth-1:0] req_mu,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_p_normal,
   output logic signed [31:0] rsp_p_tangent,
   output logic [1:0]         rsp_regime,
   output logic               rsp_status
);
   logic           front_stall, back_stall;
   logic           f_valid;
   front_item_type f_item;
   logic [1:0]     q_count_ff, q_count_in;
   front_item_type q_head_ff, q_head_in, q_next_ff, q_next_in;
   logic           q_push, q_pop, q_valid;

   assign back_stall  = rsp_valid && !rsp_ready;
   assign front_stall = q_count_ff == 2'd2;
   assign q_valid     = q_count_ff != 2'd0;
   assign q_push      = f_valid && !front_stall;
   assign q_pop       = q_valid && !back_stall;

   always_comb begin
      q_count_in = q_count_ff;
      q_head_in  = q_head_ff;
      q_next_in  = q_next_ff;
      case ({q_push, q_pop})
         2'b11: begin
            // push with a pop only happens with one entry held
            q_head_in = f_item;
         end
         2'b10: begin
            if (q_count_ff == 2'd0) q_head_in = f_item;
            else q_next_in = f_item;
            q_count_in = q_count_ff + 2'd1;
         end
         2'b01: begin
            q_head_in  = q_next_ff;
            q_count_in = q_count_ff - 2'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) q_count_ff <= 2'd0;
      else q_count_ff <= q_count_in;
   end

   always_ff @(posedge clock) begin
      q_head_ff <= q_head_in;
      q_next_ff <= q_next_in;
   end

   fc2d_front u_front (
      .clock, .reset, .req_valid, .req_ready,
      .req_w_nn, .req_w_tn, .req_w_nt, .req_w_tt, .req_det,
      .req_q_normal, .req_q_tangent, .req_mu,
      .stall(front_stall), .out_valid(f_valid), .out_item(f_item)
   );

   fc2d_back #(.FracBits(FRAC_BITS)) u_back (
      .clock, .reset, .in_valid(q_valid), .in_item(q_head_ff), .stall(back_stall),
      .out_valid(rsp_valid), .out_p_normal(rsp_p_normal), .out_p_tangent(rsp_p_tangent),
      .out_regime(rsp_regime), .out_status(rsp_status)
   );
endmodule

// ===== tb/friction_contact_2d_local_solve_checker.sv =====
module friction_contact_2d_local_solve_checker
   import fc2d_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [31:0] req_w_nn,
   input  logic signed [31:0] req_w_tn,
   input  logic signed [31:0] req_w_nt,
   input  logic signed [31:0] req_w_tt,
   input  logic signed [31:0] req_det,
   input  logic signed [31:0] req_q_normal,
   input  logic signed [31:0] req_q_tangent,
   input  logic [MuWidth-1:0] req_mu,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [31:0] rsp_p_normal,
   input  logic signed [31:0] rsp_p_tangent,
   input  logic [1:0]         rsp_regime,
   input  logic               rsp_status,
   output int                 fail_count,
   output int                 reactions_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [127:0] QuotCap = 128'hFF_FFFF_FFFF;

   typedef struct {
      logic [31:0] p_normal;
      logic [31:0] p_tangent;
      logic [1:0]  regime;
      logic        status;
   } reaction_type;

   reaction_type reaction_q[$];

   assign reactions_pending = reaction_q.size();

   function automatic longint saturate32(bit neg, logic [127:0] m, inout bit st);
      if (neg) begin
         if (m > 128'h8000_0000) begin
            st = 1'b1;
            return -longint'(64'h8000_0000);
         end
         return -longint'(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF) begin
         st = 1'b1;
         return longint'(64'h7FFF_FFFF);
      end
      return longint'(m[63:0]);
   endfunction

   // Truncating signed divide; magnitude capped at 40 bits before the 32-bit clamp.
   function automatic longint divide_sat(bit nneg, logic [127:0] num, longint den,
                                         inout bit st);
      logic [127:0] dm;
      logic [127:0] q;
      if (den == 0) begin
         st = 1'b1;
         if (num == 0) return 0;
         return saturate32(nneg, QuotCap, st);
      end
      dm = den < 0 ? 128'(-den) : 128'(den);
      q  = num / dm;
      if (q > QuotCap) q = QuotCap;
      if (q == 0) return 0;
      return saturate32(nneg ^ (den < 0), q, st);
   endfunction

   function automatic void cross_diff(longint a, longint b, longint c, longint d,
                                      output bit neg, output logic [127:0] m);
      logic signed [65:0] diff;
      diff = $signed(66'(a * b)) - $signed(66'(c * d));
      neg  = diff < 0;
      m    = neg ? 128'(-diff) : 128'(diff);
   endfunction

   function automatic reaction_type solve_contact(longint wnn, longint wtn, longint wnt,
                                                  longint wtt, longint det, longint qn,
                                                  longint qt, longint mu);
      reaction_type r;
      bit        st, neg, pos_edge, tneg;
      logic [127:0] m;
      longint    pn, pt, mupn, ptw, den, tm;
      st = 1'b0;
      pn = 0;
      pt = 0;
      r.regime = RegimeSeparated;
      if (qn <= 0) begin
         cross_diff(wnt, qt, wtt, qn, neg, m);
         pn = divide_sat(neg, m, det, st);
         cross_diff(wtn, qn, wnn, qt, neg, m);
         pt = divide_sat(neg, m, det, st);
         r.regime = RegimeStick;
         mupn = mu * pn;
         ptw  = pt * 65536;
         if ((ptw < 0 ? -ptw : ptw) > mupn) begin
            // outside the cone: project onto the edge picked by the sign
            pos_edge = !(ptw + mupn < 0);
            den = wnn * 65536 + (pos_edge ? mu * wnt : -(mu * wnt));
            pn  = divide_sat(1'b0, 128'(-qn) << (FracBitsDef + MuFrac), den, st);
            tm  = (mu * (pn < 0 ? -pn : pn)) >>> MuFrac;
            tneg = pos_edge ? (pn < 0) : (pn > 0);
            pt  = tm == 0 ? 0 : saturate32(tneg, 128'(tm), st);
            r.regime = pos_edge ? RegimeSlidePos : RegimeSlideNeg;
         end
      end
      r.p_normal  = pn[31:0];
      r.p_tangent = pt[31:0];
      r.status    = st;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      reaction_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            reaction_q.push_back(solve_contact(req_w_nn, req_w_tn, req_w_nt, req_w_tt,
                                               req_det, req_q_normal, req_q_tangent,
                                               longint'(req_mu)));
         if (rsp_valid && rsp_ready) begin
            if (reaction_q.size() == 0) begin
               report_mismatch("unexpected transfer", 32'(rsp_regime), 32'd0);
            end else begin
               want = reaction_q.pop_front();
               if (rsp_p_normal !== want.p_normal)
                  report_mismatch("p_normal", rsp_p_normal, want.p_normal);
               if (rsp_p_tangent !== want.p_tangent)
                  report_mismatch("p_tangent", rsp_p_tangent, want.p_tangent);
               if (rsp_regime !== want.regime)
                  report_mismatch("regime", 32'(rsp_regime), 32'(want.regime));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
      end
   end

endmodule

// ===== tb/friction_contact_2d_local_solve_unit_tb.sv =====
module friction_contact_2d_local_solve_unit_tb
   import fc2d_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 1950;
   localparam int IdleLimit   = 6000;
   localparam int DrainCycles = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_w_nn = '0, req_w_tn = '0, req_w_nt = '0, req_w_tt = '0;
   logic signed [31:0] req_det = '0, req_q_normal = '0, req_q_tangent = '0;
   logic [MuWidth-1:0] req_mu = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_p_normal, rsp_p_tangent;
   logic [1:0]         rsp_regime;
   logic               rsp_status;
   int                 fail_count, reactions_pending;
   int                 idle_cycles = 0;
   int                 burst_left = 0;

   always #5 clock = ~clock;

   friction_contact_2d_local_solve_unit u_dut (.*);

   friction_contact_2d_local_solve_checker u_checker (.*);

   // receiver: alternate between always ready, random stalls and long stalls
   always @(posedge clock) begin
      int mode;
      mode = int'($realtime / 3000.0);
      case (mode % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ($urandom_range(0, 1) != 0);
         default: rsp_ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("FAIL friction_contact_2d_local_solve_unit");
         $finish;
      end
   end

   function automatic logic [31:0] rand_signed_small(int lim);
      return 32'($signed($urandom_range(0, 2 * lim)) - lim);
   endfunction

   task automatic send_contact(logic [31:0] wnn, logic [31:0] wtn, logic [31:0] wnt,
                               logic [31:0] wtt, logic [31:0] det, logic [31:0] qn,
                               logic [31:0] qt, logic [MuWidth-1:0] mu);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid     <= 1'b1;
      req_w_nn      <= wnn;
      req_w_tn      <= wtn;
      req_w_nt      <= wnt;
      req_w_tt      <= wtt;
      req_det       <= det;
      req_q_normal  <= qn;
      req_q_tangent <= qt;
      req_mu        <= mu;
      do @(posedge clock); while (!req_ready);
   endtask

   // block with a positive diagonal and a consistent determinant
   task automatic send_well_formed(bit full_mu);
      longint wnn, wtt, wnt, wtn;
      logic [31:0] qn;
      wnn = $urandom_range(1 << 14, 8 << 16);
      wtt = $urandom_range(1 << 14, 8 << 16);
      wnt = $signed(rand_signed_small(1 << 15));
      wtn = $signed(rand_signed_small(1 << 15));
      qn  = ($urandom_range(0, 7) == 0) ? 32'($urandom_range(0, 4 << 16))
                                        : 32'(-$signed($urandom_range(0, 4 << 16)));
      send_contact(32'(wnn), 32'(wtn), 32'(wnt), 32'(wtt),
                   32'((wnn * wtt - wnt * wtn) >>> 16), qn, rand_signed_small(4 << 16),
                   full_mu ? MuWidth'($urandom) : MuWidth'($urandom_range(0, 1 << 16)));
   endtask

   initial begin
      int kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // separated, touching, zero divisors, extremes, both cone edges
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h7FFF_FFFF, 32'h1234, 18'h3FFFF);
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'h1, 32'h8000_0000, 18'h10000);
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 0, 0, 0);
      send_contact(32'h10000, 0, 0, 32'h10000, 0, 0, 0, 18'h8000);
      send_contact(32'h10000, 0, 0, 32'h10000, 0, 32'hFFFF_0000, 32'h10000, 18'h8000);
      send_contact(0, 0, 0, 0, 0, 32'hFFFF_0000, 32'h30000, 18'h8000);
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'h30000, 18'h8000);
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'hFFFD_0000,
                   18'h8000);
      send_contact(32'h10000, 0, 0, 32'h10000, 32'h10000, 32'hFFFF_0000, 32'h8000, 18'h10000);
      send_contact(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1,
                   32'h8000_0000, 32'h8000_0000, 18'h3FFFF);
      send_contact(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF, 18'h3FFFF);
      send_contact(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'h7FFF_FFFF, 0);
      send_contact(32'h10000, 32'h20000, 32'hFFFE_0000, 32'h10000, 32'hFFFD_0000,
                   32'hFFFE_0000, 32'h10000, 18'h4000);
      send_contact(32'h10000, 0, 32'h8000, 32'h10000, 32'h10000, 32'hFFFF_0000,
                   32'h50000, 18'h20000);
      send_contact(32'h10000, 0, 32'h8000, 32'h10000, 32'h10000, 32'hFFFF_0000,
                   32'hFFFB_0000, 18'h20000);
      send_contact(32'h8000, 0, 32'h10000, 32'h10000, 32'h8000, 32'hFFFF_0000,
                   32'h50000, 18'h8000);
      for (int i = 0; i < RandomItems; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            send_well_formed(kind == 5);
         end else if (kind < 9) begin
            send_contact($urandom, $urandom, $urandom, $urandom,
                         ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom,
                         ($urandom_range(0, 3) == 0) ? $urandom : -$urandom_range(0, 1 << 30),
                         $urandom, MuWidth'($urandom));
         end else begin
            send_contact(rand_signed_small(1 << 17), rand_signed_small(1 << 17),
                         rand_signed_small(1 << 17), rand_signed_small(1 << 17),
                         ($urandom_range(0, 1) == 0) ? 32'd0 : rand_signed_small(1 << 10),
                         -$urandom_range(0, 1 << 18), rand_signed_small(1 << 18),
                         MuWidth'($urandom));
         end
      end
      req_valid <= 1'b0;
      while (reactions_pending != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && reactions_pending == 0) begin
         $display("PASS friction_contact_2d_local_solve_unit");
      end else begin
         $display("FAIL friction_contact_2d_local_solve_unit");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/fc2d_pkg.sv
sv/fc2d_divider.sv
sv/fc2d_front.sv
sv/fc2d_back.sv
sv/friction_contact_2d_local_solve_unit.sv
tb/friction_contact_2d_local_solve_checker.sv
tb/friction_contact_2d_local_solve_unit_tb.sv
